@@ rtl/asa_pkg.sv @@
// Shared types and constants for the aligned stack allocator.
package asa_pkg;

    // Field widths of the beats
    localparam int unsigned SizeW  = 32;
    localparam int unsigned OffW   = 40;
    localparam int unsigned KindW  = 2;
    localparam int unsigned AlignW = 5;
    localparam int unsigned CapW   = 32;
    localparam int unsigned IdxW   = 2;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Memory kinds
    localparam logic [KindW-1:0] KIND_NONE = 2'd0;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_FREE = 2'd1;
    localparam logic [1:0] ST_ORDER    = 2'd2;
    localparam logic [1:0] ST_NO_ROOM  = 2'd3;

    // Configuration register indexes
    localparam logic [IdxW-1:0] REG_MEMORY_KIND = 2'd0;
    localparam logic [IdxW-1:0] REG_ALIGN_LOG2  = 2'd1;
    localparam logic [IdxW-1:0] REG_CAPACITY    = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [SizeW-1:0]  req_size;
        logic [OffW-1:0]   seg_offset;
        logic [KindW-1:0]  seg_kind;
        logic              seg_null;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OffW-1:0]   out_offset;
        logic [SizeW-1:0]  out_size;
        logic [OffW-1:0]   in_use;
        logic [OffW-1:0]   peak_use;
    } out_t;

    typedef struct packed {
        logic [KindW-1:0]  memory_kind;
        logic [AlignW-1:0] align_log2;
        logic [CapW-1:0]   capacity;
    } cfg_t;

endpackage

@@ rtl/asa_core.sv @@
// Allocate/free datapath: computes one result and the next top and peak.
module asa_core #(
    parameter int unsigned SIZE_BITS  = 32,
    parameter int unsigned TOTAL_BITS = 40
) (
    input  asa_pkg::cfg_t          cfg,
    input  asa_pkg::in_t           item,
    input  logic [TOTAL_BITS-1:0]  top,
    input  logic [TOTAL_BITS-1:0]  peak,
    output asa_pkg::out_t          result,
    output logic [TOTAL_BITS-1:0]  top_next,
    output logic [TOTAL_BITS-1:0]  peak_next
);

    logic                  counting;
    logic [SIZE_BITS-1:0]  sz;
    logic [SIZE_BITS-1:0]  gmask;
    logic [SIZE_BITS-1:0]  asz;
    logic [TOTAL_BITS-1:0] sz_ext;
    logic [TOTAL_BITS-1:0] asz_ext;
    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS:0]   cap_ext;
    logic [63:0]           off_wide;
    logic [TOTAL_BITS-1:0] off;
    logic [TOTAL_BITS-1:0] free_base;
    logic [1:0]            status;
    logic [TOTAL_BITS-1:0] res_off;
    logic [SIZE_BITS-1:0]  res_size;
    logic [63:0]           top_wide;
    logic [63:0]           peak_wide;
    logic [63:0]           roff_wide;

    // Round the size up to the granule; a shift past the width gives a full mask
    assign counting = (cfg.memory_kind == asa_pkg::KIND_NONE);
    assign sz       = item.req_size[SIZE_BITS-1:0];
    assign gmask    = ~({SIZE_BITS{1'b1}} << cfg.align_log2);
    assign asz      = (sz + gmask) & ~gmask;

    assign sz_ext    = TOTAL_BITS'(sz);
    assign asz_ext   = TOTAL_BITS'(asz);
    assign sum       = {1'b0, top} + {1'b0, asz_ext};
    assign cap_ext   = (TOTAL_BITS + 1)'(cfg.capacity);
    assign off_wide  = 64'(item.seg_offset);
    assign off       = off_wide[TOTAL_BITS-1:0];
    assign free_base = top - sz_ext;

    // Check the request and pick the next state
    always_comb
    begin
        status    = asa_pkg::ST_OK;
        res_off   = '0;
        res_size  = '0;
        top_next  = top;
        peak_next = peak;
        if (item.mode == asa_pkg::MODE_ALLOC)
        begin
            if (counting)
            begin
                res_off  = top;
                res_size = asz;
                top_next = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
            end
            else if ((sum <= cap_ext) || (asz == '0))
            begin
                res_off  = top;
                res_size = asz;
                top_next = sum[TOTAL_BITS-1:0];
            end
            else
            begin
                status = asa_pkg::ST_NO_ROOM;
            end
            if ((status == asa_pkg::ST_OK) && (top_next > peak))
            begin
                peak_next = top_next;
            end
        end
        else
        begin
            if (item.seg_kind != cfg.memory_kind)
            begin
                status = asa_pkg::ST_BAD_FREE;
            end
            else if (item.seg_null && !counting)
            begin
                status = asa_pkg::ST_BAD_FREE;
            end
            else if (off != free_base)
            begin
                status = asa_pkg::ST_ORDER;
            end
            else if (sz_ext > top)
            begin
                status = asa_pkg::ST_BAD_FREE;
            end
            else
            begin
                top_next = free_base;
            end
        end
    end

    // Fit the internal widths onto the result fields
    assign top_wide  = 64'(top_next);
    assign peak_wide = 64'(peak_next);
    assign roff_wide = 64'(res_off);

    always_comb
    begin
        result.status     = status;
        result.out_offset = roff_wide[asa_pkg::OffW-1:0];
        result.out_size   = asa_pkg::SizeW'(res_size);
        result.in_use     = top_wide[asa_pkg::OffW-1:0];
        result.peak_use   = peak_wide[asa_pkg::OffW-1:0];
    end

endmodule

@@ rtl/aligned_stack_allocator_unit.sv @@
// Top level of the aligned bump-pointer stack allocator.
// Usage:
//   in_valid/in_stall/in_item carry request beats (allocate or free the newest
//   segment); out_valid/out_stall/out_item carry one result beat per request.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write memory_kind (0), align_log2 (1)
//   and capacity (2); cfg_ready is always high. Write only while idle.
// Path: a request accepted into the input register has its result registered
//   in the result register, where out_valid rises.
// Throughput: one request per cycle unless out_stall holds the result. Top of
//   stack loops through add/subtract and compare, updated as requests advance.
// Reset (rst_n low, asynchronous): top, peak and config registers go to zero
//   and both beat stages empty; the payload registers are not reset.
// Stall: while out_stall holds a full result register, the input register
//   holds too and in_stall rises once it is full; no beat is lost or repeated.
module aligned_stack_allocator_unit #(
    parameter int unsigned SIZE_BITS  = 32,
    parameter int unsigned TOTAL_BITS = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  asa_pkg::in_t                in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output asa_pkg::out_t               out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [asa_pkg::IdxW-1:0]    cfg_index,
    input  logic [asa_pkg::CapW-1:0]    cfg_data
);

    asa_pkg::cfg_t         cfg_reg;
    asa_pkg::in_t          in_item_reg;
    logic                  in_valid_reg;
    asa_pkg::out_t         out_item_reg;
    logic                  out_valid_reg;
    logic [TOTAL_BITS-1:0] top_reg;
    logic [TOTAL_BITS-1:0] top_next;
    logic [TOTAL_BITS-1:0] peak_reg;
    logic [TOTAL_BITS-1:0] peak_next;
    asa_pkg::out_t         result;
    logic                  advance;
    logic                  in_take;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                asa_pkg::REG_MEMORY_KIND: cfg_reg.memory_kind <= cfg_data[asa_pkg::KindW-1:0];
                asa_pkg::REG_ALIGN_LOG2:  cfg_reg.align_log2  <= cfg_data[asa_pkg::AlignW-1:0];
                asa_pkg::REG_CAPACITY:    cfg_reg.capacity    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    asa_core #(
        .SIZE_BITS  (SIZE_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_core (
        .cfg       (cfg_reg),
        .item      (in_item_reg),
        .top       (top_reg),
        .peak      (peak_reg),
        .result    (result),
        .top_next  (top_next),
        .peak_next (peak_next)
    );

    // Advance the beat stages and the stack state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            top_reg       <= '0;
            peak_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    top_reg  <= top_next;
                    peak_reg <= peak_next;
                end
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payloads without reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (advance && in_valid_reg)
        begin
            out_item_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_peak_covers_top: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= top_reg)
        else $error("peak below top of stack");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak decreased");

    a_fail_keeps_top: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && (result.status != asa_pkg::ST_OK))
        |=> (top_reg == $past(top_reg)))
        else $error("failed request changed top of stack");

    a_free_keeps_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && (in_item_reg.mode == asa_pkg::MODE_FREE))
        |=> $stable(peak_reg))
        else $error("free changed peak");
`endif

endmodule
